### src/adsr_pkg.sv
`default_nettype none

package adsr_pkg;

  // Fixed field widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned LEVEL_W   = 15;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned LEVEL_SH  = COUNT_W - LEVEL_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned QCNT_W    = $clog2(COUNT_W);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_MS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_MS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE       = 3'd4;

  // Configuration reset values
  localparam logic [MS_W-1:0]    RST_ATTACK_MS  = 16'd100;
  localparam logic [MS_W-1:0]    RST_DECAY_MS   = 16'd250;
  localparam logic [LEVEL_W-1:0] RST_SUSTAIN    = 15'd16000;
  localparam logic [MS_W-1:0]    RST_RELEASE_MS = 16'd50;
  localparam logic [LEVEL_W-1:0] RST_GATE       = 15'd0;

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_ADV,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] trigger;
    logic signed [SAMPLE_W-1:0] audio_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] audio_out;
    logic [2:0]                 phase;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic adv;
    logic mul;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tick;
    logic div_req;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

### src/adsr_envelope_vca_core.sv
// ADSR envelope generator with a built-in VCA.
// Input channel (in_valid / in_stall / in_data): one trigger and one audio
// sample per transfer. Every 2**CONTROL_DIVIDER_LOG2-th sample, starting with
// the first after reset, is a control tick that evaluates the trigger and
// steps the envelope. Output channel (out_valid / out_stall / out_data): one
// scaled sample and the envelope phase per input transfer, in order.
// Configuration: cfg_we writes cfg_wdata into the register at cfg_idx
// (attack ms, decay ms, sustain level, release ms, gate level); write only
// while the block holds no item.
// Sequence: an item on a tick that needs a new step rate passes the load,
// evaluate, divide (on the 32-step serial divider), advance, multiply and
// output states; a tick without a rate update skips divide, and any other
// sample skips advance too. The result turns valid as the output register loads.
// Reset (rst_n low, synchronous) turns the envelope off, clears the tick
// counter and loads the default configuration.
// A stalled receiver holds the result in the output register; one further
// item is accepted and computed meanwhile, then in_stall stays high until
// the held result is transferred.
`default_nettype none

module adsr_envelope_vca_core
  import adsr_pkg::*;
#(
  parameter int unsigned CONTROL_DIVIDER_LOG2 = 5,
  parameter int unsigned SAMPLE_RATE          = 48000
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [MS_W-1:0]      cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  adsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  adsr_dp #(
    .CONTROL_DIVIDER_LOG2 (CONTROL_DIVIDER_LOG2),
    .SAMPLE_RATE          (SAMPLE_RATE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### src/adsr_div.sv
`default_nettype none

module adsr_div
  import adsr_pkg::*;
#(
  parameter int unsigned DW = 24
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [COUNT_W-1:0] dividend,
  input  wire logic [DW-1:0]      divisor,
  output logic                    done,
  output logic [COUNT_W-1:0]      quotient
);

  logic [DW-1:0]      rem_r, rem_nxt;
  logic [COUNT_W-1:0] quo_r, quo_nxt;
  logic [DW-1:0]      dvs_r, dvs_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DW:0]        trial;
  logic [DW:0]        diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[COUNT_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
      quo_nxt = {quo_r[COUNT_W-2:0], ~diff[DW]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == QCNT_W'(COUNT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still iterating");
`endif

endmodule

`default_nettype wire

### src/adsr_dp.sv
`default_nettype none

module adsr_dp
  import adsr_pkg::*;
#(
  parameter int unsigned CONTROL_DIVIDER_LOG2 = 5,
  parameter int unsigned SAMPLE_RATE          = 48000
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cmd_t                 cmd,
  output sts_t                      sts,
  input  wire in_item_t             in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [MS_W-1:0]      cfg_wdata,
  output out_item_t                 out_data
);

  localparam int unsigned FACTOR = SAMPLE_RATE / 1000;
  localparam int unsigned DIV_W  = MS_W + $clog2(FACTOR + 1);
  localparam int unsigned TICK_W = (CONTROL_DIVIDER_LOG2 == 0) ? 1 : CONTROL_DIVIDER_LOG2;

  // Configuration registers
  logic [MS_W-1:0]    attack_ms_r, decay_ms_r, release_ms_r;
  logic [LEVEL_W-1:0] sustain_r, gate_r;

  // Item and envelope state
  logic signed [SAMPLE_W-1:0] trig_r, audio_r, prev_r;
  logic [TICK_W-1:0]          tick_cnt_r, tick_cnt_nxt;
  logic                       tick_r;
  logic [COUNT_W-1:0]         count_r, count_nxt;
  phase_t                     phase_r, phase_ev, phase_nxt;
  logic [LEVEL_W-1:0]         level_r;
  logic [COUNT_W-1:0]         rel_step_r;
  logic                       div_used_r, ms_zero_r;
  logic signed [2*SAMPLE_W-1:0] prod_r;
  out_item_t                  out_r;

  // Evaluation and step logic
  logic                 rel_entry, div_req;
  logic [MS_W-1:0]      ms_sel;
  logic [COUNT_W-1:0]   span_sel;
  logic [DIV_W-1:0]     divisor;
  logic                 div_done;
  logic [COUNT_W-1:0]   quotient;
  logic [COUNT_W+CONTROL_DIVIDER_LOG2-1:0] q_wide;
  logic [COUNT_W-1:0]   fresh_step, step;
  logic [COUNT_W-1:0]   sus, gate;
  logic [COUNT_W:0]     sum;

  assign sus  = {sustain_r, LEVEL_SH'(0)};
  assign gate = {gate_r, LEVEL_SH'(0)};

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_ms_r  <= RST_ATTACK_MS;
      decay_ms_r   <= RST_DECAY_MS;
      sustain_r    <= RST_SUSTAIN;
      release_ms_r <= RST_RELEASE_MS;
      gate_r       <= RST_GATE;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ATTACK_MS:  attack_ms_r  <= cfg_wdata;
        CFG_DECAY_MS:   decay_ms_r   <= cfg_wdata;
        CFG_SUSTAIN:    sustain_r    <= cfg_wdata[LEVEL_W-1:0];
        CFG_RELEASE_MS: release_ms_r <= cfg_wdata;
        CFG_GATE:       gate_r       <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Evaluate the trigger and pick the divider operands
  always_comb begin
    phase_ev  = phase_r;
    rel_entry = 1'b0;
    if (trig_r == '0) begin
      if (!(phase_r inside {PH_OFF, PH_RELEASE})) begin
        phase_ev  = PH_RELEASE;
        rel_entry = 1'b1;
      end
    end else if (!trig_r[SAMPLE_W-1]) begin
      if (prev_r[SAMPLE_W-1] || prev_r == '0) phase_ev = PH_ATTACK;
    end else begin
      if (!prev_r[SAMPLE_W-1]) phase_ev = PH_ATTACK;
    end
    div_req = rel_entry || (phase_ev inside {PH_ATTACK, PH_DECAY});
    if (rel_entry) begin
      ms_sel   = release_ms_r;
      span_sel = count_r;
    end else if (phase_ev == PH_ATTACK) begin
      ms_sel   = attack_ms_r;
      span_sel = '1;
    end else begin
      ms_sel   = decay_ms_r;
      span_sel = '1 - sus;
    end
  end

  assign divisor = DIV_W'(ms_sel) * DIV_W'(FACTOR);

  adsr_div #(
    .DW (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.eval && div_req),
    .dividend (span_sel),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Scale the quotient to the control rate, saturating
  assign q_wide     = (COUNT_W + CONTROL_DIVIDER_LOG2)'(quotient) << CONTROL_DIVIDER_LOG2;
  assign fresh_step = (ms_zero_r || (q_wide >> COUNT_W) != '0) ? '1 : q_wide[COUNT_W-1:0];
  assign step       = div_used_r ? fresh_step : rel_step_r;
  assign sum        = {1'b0, count_r} + {1'b0, step};

  // Advance the envelope counter by one control tick
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    case (phase_r)
      PH_ATTACK: begin
        if (sum[COUNT_W]) begin
          count_nxt = '1;
          phase_nxt = PH_DECAY;
        end else begin
          count_nxt = sum[COUNT_W-1:0];
        end
      end
      PH_DECAY: begin
        count_nxt = (step > count_r) ? '0 : count_r - step;
        if (count_nxt <= sus) begin
          count_nxt = sus;
          phase_nxt = PH_SUSTAIN;
        end else if (count_nxt < gate) begin
          count_nxt = '0;
          phase_nxt = PH_OFF;
        end
      end
      PH_SUSTAIN: begin
        if (sus == '0) phase_nxt = PH_OFF;
        count_nxt = sus;
      end
      PH_RELEASE: begin
        if (step > count_r) begin
          count_nxt = '0;
          phase_nxt = PH_OFF;
        end else begin
          count_nxt = count_r - step;
        end
      end
      default: begin
        count_nxt = '0;
        phase_nxt = PH_OFF;
      end
    endcase
  end

  // Count samples toward the next control tick
  assign tick_cnt_nxt = (CONTROL_DIVIDER_LOG2 == 0) ? '0 : tick_cnt_r + 1'b1;

  // Control state of the envelope
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r <= '0;
      tick_r     <= 1'b0;
      count_r    <= '0;
      phase_r    <= PH_OFF;
      level_r    <= '0;
      prev_r     <= '0;
      rel_step_r <= '0;
      div_used_r <= 1'b0;
      ms_zero_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        tick_cnt_r <= tick_cnt_nxt;
        tick_r     <= (tick_cnt_r == '0);
      end
      if (cmd.eval) begin
        phase_r    <= phase_ev;
        prev_r     <= trig_r;
        div_used_r <= div_req;
        ms_zero_r  <= (ms_sel == '0);
      end
      if (cmd.adv) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        level_r <= count_nxt[COUNT_W-1:LEVEL_SH];
        if (div_used_r && phase_r == PH_RELEASE) rel_step_r <= fresh_step;
      end
    end
  end

  // Hold the item, the product and the result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      trig_r  <= in_data.trigger;
      audio_r <= in_data.audio_in;
    end
    if (cmd.mul) prod_r <= $signed({1'b0, level_r}) * audio_r;
    if (cmd.out_load) begin
      out_r.audio_out <= prod_r[LEVEL_W+SAMPLE_W-1:LEVEL_W];
      out_r.phase     <= phase_r;
    end
  end

  assign sts.tick     = tick_r;
  assign sts.div_req  = div_req;
  assign sts.div_done = div_done;
  assign out_data     = out_r;

`ifndef NO_ASSERTIONS
  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_OFF |-> count_r == '0)
    else $error("envelope counter not cleared while off");

  a_level_track: assert property (@(posedge clk) disable iff (!rst_n)
    level_r == count_r[COUNT_W-1:LEVEL_SH])
    else $error("envelope level out of step with counter");
`endif

endmodule

`default_nettype wire

### src/adsr_ctrl.sv
`default_nettype none

module adsr_ctrl
  import adsr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.tick) begin
          cmd.eval  = 1'b1;
          state_nxt = sts.div_req ? ST_DIV : ST_ADV;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_ADV;
      end
      ST_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Set on a new result, drop when the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && out_valid_r && out_stall |=> state_r == ST_OUT)
    else $error("result dropped while output register full");

  a_adv_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ADV |-> $past(state_r) == ST_DIV || $past(state_r) == ST_EVAL)
    else $error("advance reached without evaluation");
`endif

endmodule

`default_nettype wire
